>>> rtl/aqs_pkg.sv
// ----------------------------------------------------------------------------
// aqs_pkg - air quality sub-index shared definitions
// Breakpoint tables, segment descriptors and the classification functions.
// ----------------------------------------------------------------------------
package aqs_pkg;

    // Concentration bits taken from each input field
    localparam int CONC_WIDTH   = 12;
    localparam int FIELD_W      = 12;
    localparam int USE_W        = (CONC_WIDTH < FIELD_W) ? CONC_WIDTH : FIELD_W;
    localparam int NPTS         = 8;
    localparam int SEG_W        = $clog2(NPTS);
    localparam int NUM_W        = 4;
    localparam int RECIP_W      = 17;
    localparam int RECIP_SHIFT  = 16;
    localparam int ILO_W        = 9;
    localparam int PROD_W       = FIELD_W + NUM_W;
    localparam int QUO_W        = 13;
    localparam int SUM_W        = QUO_W + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_W-1:0] OUT_MAX = 12'd4095;

    typedef logic [FIELD_W-1:0] conc_t;

    // Breakpoint tables; the last entry starts the open-ended top segment
    localparam conc_t PM25_BP [NPTS] = '{12'd0, 12'd35, 12'd75, 12'd115,
                                         12'd150, 12'd250, 12'd350, 12'd500};
    localparam conc_t PM10_BP [NPTS] = '{12'd0, 12'd50, 12'd150, 12'd250,
                                         12'd350, 12'd420, 12'd500, 12'd600};

    // Segment base concentration (PM2.5 top segment passes through)
    localparam conc_t PM25_LO [NPTS] = '{12'd0, 12'd35, 12'd75, 12'd115,
                                         12'd150, 12'd250, 12'd350, 12'd0};

    // Index at segment base
    localparam logic [ILO_W-1:0] PM25_ILO [NPTS] = '{9'd0, 9'd50, 9'd100, 9'd150,
                                                      9'd200, 9'd300, 9'd400, 9'd0};
    localparam logic [ILO_W-1:0] PM10_ILO [NPTS] = '{9'd0, 9'd50, 9'd100, 9'd150,
                                                      9'd200, 9'd300, 9'd400, 9'd500};

    // Slope reduced to num/den; den applied as ceil(2^16/den) reciprocal
    localparam logic [NUM_W-1:0] PM25_NUM [NPTS] = '{4'd10, 4'd5, 4'd5, 4'd10,
                                                      4'd1, 4'd1, 4'd2, 4'd1};
    localparam logic [NUM_W-1:0] PM10_NUM [NPTS] = '{4'd1, 4'd1, 4'd1, 4'd1,
                                                      4'd10, 4'd5, 4'd1, 4'd4};
    localparam logic [RECIP_W-1:0] PM25_RECIP [NPTS] = '{17'd9363, 17'd16384,
        17'd16384, 17'd9363, 17'd65536, 17'd65536, 17'd21846, 17'd65536};
    localparam logic [RECIP_W-1:0] PM10_RECIP [NPTS] = '{17'd65536, 17'd32768,
        17'd32768, 17'd32768, 17'd9363, 17'd16384, 17'd65536, 17'd13108};

    typedef struct packed {
        conc_t                  x;      // offset into segment
        logic [NUM_W-1:0]       num;
        logic [RECIP_W-1:0]     recip;
        logic [ILO_W-1:0]       ilo;
    } seg_t;

    typedef struct packed {
        seg_t pm25;
        seg_t pm10;
    } item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
    } queue_status_t;

    function automatic seg_t classify_pm25(input conc_t c);
        seg_t             r;
        logic [SEG_W-1:0] k;
        k = '0;
        for (int i = 1; i < NPTS; i++)
        begin
            if (c >= PM25_BP[i])
            begin
                k = SEG_W'(i);
            end
        end
        r.x     = c - PM25_LO[k];
        r.num   = PM25_NUM[k];
        r.recip = PM25_RECIP[k];
        r.ilo   = PM25_ILO[k];
        return r;
    endfunction

    function automatic seg_t classify_pm10(input conc_t c);
        seg_t             r;
        logic [SEG_W-1:0] k;
        k = '0;
        for (int i = 1; i < NPTS; i++)
        begin
            if (c >= PM10_BP[i])
            begin
                k = SEG_W'(i);
            end
        end
        r.x     = c - PM10_BP[k];
        r.num   = PM10_NUM[k];
        r.recip = PM10_RECIP[k];
        r.ilo   = PM10_ILO[k];
        return r;
    endfunction

endpackage

>>> rtl/aqs_front.sv
// ----------------------------------------------------------------------------
// aqs_front - input classification
// Masks the concentrations and picks each one's breakpoint segment.
// ----------------------------------------------------------------------------
module aqs_front
(
    input  logic                 [aqs_pkg::FIELD_W-1:0] pm25_conc,
    input  logic                 [aqs_pkg::FIELD_W-1:0] pm10_conc,
    output aqs_pkg::item_t                              item
);
    import aqs_pkg::*;

    conc_t c25;
    conc_t c10;

    // Keep only the used concentration bits
    assign c25 = FIELD_W'(pm25_conc[USE_W-1:0]);
    assign c10 = FIELD_W'(pm10_conc[USE_W-1:0]);

    always_comb
    begin
        item.pm25 = classify_pm25(c25);
        item.pm10 = classify_pm10(c10);
    end

endmodule

>>> rtl/aqs_queue.sv
// ----------------------------------------------------------------------------
// aqs_queue - short queue between front and back
// Two-entry register queue of classified items.
// ----------------------------------------------------------------------------
module aqs_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  aqs_pkg::item_t         push_item,
    input  logic                   pop,
    output aqs_pkg::item_t         pop_item,
    output aqs_pkg::queue_status_t status
);
    import aqs_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/aqs_back.sv
// ----------------------------------------------------------------------------
// aqs_back - interpolation datapath
// Slope multiply, reciprocal divide, offset add, saturate and maximum.
// ----------------------------------------------------------------------------
module aqs_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  aqs_pkg::item_t                       item,
    input  aqs_pkg::queue_status_t               status,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic           [aqs_pkg::FIELD_W-1:0] pm25_index,
    output logic           [aqs_pkg::FIELD_W-1:0] pm10_index,
    output logic           [aqs_pkg::FIELD_W-1:0] max_index
);
    import aqs_pkg::*;

    localparam int FULL_W = PROD_W + RECIP_W;

    logic                 advance;

    // Stage 1: slope numerator product
    logic                 s1_valid_reg;
    logic [PROD_W-1:0]    s1_p25_reg;
    logic [PROD_W-1:0]    s1_p10_reg;
    logic [RECIP_W-1:0]   s1_r25_reg;
    logic [RECIP_W-1:0]   s1_r10_reg;
    logic [ILO_W-1:0]     s1_i25_reg;
    logic [ILO_W-1:0]     s1_i10_reg;

    // Stage 2: quotient
    logic                 s2_valid_reg;
    logic [QUO_W-1:0]     s2_q25_reg;
    logic [QUO_W-1:0]     s2_q10_reg;
    logic [ILO_W-1:0]     s2_i25_reg;
    logic [ILO_W-1:0]     s2_i10_reg;

    // Output register
    logic                 out_valid_reg;
    logic [FIELD_W-1:0]   out25_reg;
    logic [FIELD_W-1:0]   out10_reg;
    logic [FIELD_W-1:0]   outmax_reg;

    logic [FULL_W-1:0]    full25;
    logic [FULL_W-1:0]    full10;
    logic [SUM_W-1:0]     sum25;
    logic [SUM_W-1:0]     sum10;
    logic [FIELD_W-1:0]   sat25;
    logic [FIELD_W-1:0]   sat10;

    // Whole pipeline moves unless a finished result is held
    assign advance = !(out_valid_reg && out_stall);
    assign pop     = advance && !status.empty;

    assign full25 = FULL_W'(s1_p25_reg) * FULL_W'(s1_r25_reg);
    assign full10 = FULL_W'(s1_p10_reg) * FULL_W'(s1_r10_reg);

    assign sum25  = SUM_W'(s2_q25_reg) + SUM_W'(s2_i25_reg);
    assign sum10  = SUM_W'(s2_q10_reg) + SUM_W'(s2_i10_reg);
    assign sat25  = (sum25 > SUM_W'(OUT_MAX)) ? OUT_MAX : sum25[FIELD_W-1:0];
    assign sat10  = (sum10 > SUM_W'(OUT_MAX)) ? OUT_MAX : sum10[FIELD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !status.empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_p25_reg <= PROD_W'(item.pm25.num) * PROD_W'(item.pm25.x);
            s1_p10_reg <= PROD_W'(item.pm10.num) * PROD_W'(item.pm10.x);
            s1_r25_reg <= item.pm25.recip;
            s1_r10_reg <= item.pm10.recip;
            s1_i25_reg <= item.pm25.ilo;
            s1_i10_reg <= item.pm10.ilo;

            s2_q25_reg <= full25[RECIP_SHIFT +: QUO_W];
            s2_q10_reg <= full10[RECIP_SHIFT +: QUO_W];
            s2_i25_reg <= s1_i25_reg;
            s2_i10_reg <= s1_i10_reg;

            out25_reg  <= sat25;
            out10_reg  <= sat10;
            outmax_reg <= (sat25 > sat10) ? sat25 : sat10;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pm25_index = out25_reg;
    assign pm10_index = out10_reg;
    assign max_index  = outmax_reg;

endmodule

>>> rtl/air_quality_subindex.sv
// ----------------------------------------------------------------------------
// air_quality_subindex - PM2.5 / PM10 air quality sub-index
// Piecewise linear sub-indices of two concentrations and their maximum.
// ----------------------------------------------------------------------------
// A pair goes from the queue via stage 1 and stage 2 to the output register.
// Throughput: one pair per unstalled cycle, set by the 3-stage back pipeline
//   fed from a two-entry queue, each stage one multiply or one add/compare.
// Reset: rst_n clears the queue and all pipeline valid flags; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module air_quality_subindex
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [aqs_pkg::FIELD_W-1:0]  pm25_conc,
    input  logic [aqs_pkg::FIELD_W-1:0]  pm10_conc,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [aqs_pkg::FIELD_W-1:0]  pm25_index,
    output logic [aqs_pkg::FIELD_W-1:0]  pm10_index,
    output logic [aqs_pkg::FIELD_W-1:0]  max_index
);
    import aqs_pkg::*;

    item_t         front_item;
    item_t         queue_item;
    queue_status_t queue_status;
    logic          queue_pop;

    // Front: classify each concentration into its breakpoint segment,
    // giving offset, slope numerator, reciprocal of denominator and base index
    aqs_front u_front
    (
        .pm25_conc (pm25_conc),
        .pm10_conc (pm10_conc),
        .item      (front_item)
    );

    // Hold input transfers off only when the queue is full; the flag is
    // registered, so it never looks at in_valid
    assign in_stall = queue_status.full;

    // Queue: decouple input acceptance from output back-pressure
    aqs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_item),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .status    (queue_status)
    );

    // Back: multiply by numerator, divide through the reciprocal, add the
    // base index, saturate and take the maximum; the pipeline freezes as a
    // whole while a result is held at the output
    aqs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (queue_item),
        .status     (queue_status),
        .pop        (queue_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pm25_index (pm25_index),
        .pm10_index (pm10_index),
        .max_index  (max_index)
    );

endmodule

>>> verif/air_quality_subindex_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_quality_subindex_test - PM2.5 / PM10 sub-index block test
// Drives sample pairs through the block under random idling on both sides,
// works out each pair's sub-indices independently and compares every result
// transfer, field by field and in order, with the oldest outstanding pair.
// ----------------------------------------------------------------------------
module air_quality_subindex_test;

    localparam int W              = aqs_pkg::FIELD_W;
    localparam int CONC_MAX       = (1 << W) - 1;
    localparam int INDEX_MAX      = 4095;
    localparam int RANDOM_PAIRS   = 1650;
    localparam int QUIET_FIRST    = 600;   // random pairs in this range see no idling
    localparam int QUIET_LAST     = 900;
    localparam int IDLE_PCT       = 22;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [W-1:0] pm25;
        logic [W-1:0] pm10;
        logic [W-1:0] top;
    } index_set_t;

    // ------------------------------------------------------------------------
    // Sub-index book: works out the indices of each accepted pair and holds
    // them until the matching result transfer turns up.
    // ------------------------------------------------------------------------
    class subindex_ledger;
        index_set_t pending[$];
        int         errors;
        int         reports;

        function new();
            errors  = 0;
            reports = 0;
        endfunction

        // Linear interpolation between breakpoints, truncating division
        function int interpolate(input bit is_pm25, input int c);
            int idx [8];
            int bp  [8];
            idx = '{0, 50, 100, 150, 200, 300, 400, 500};
            if (is_pm25)
                bp = '{0, 35, 75, 115, 150, 250, 350, 500};
            else
                bp = '{0, 50, 150, 250, 350, 420, 500, 600};
            for (int k = 0; k < 7; k++)
            begin
                if (c == bp[k])
                    return idx[k];
                if (c > bp[k] && c < bp[k+1])
                    return (idx[k+1] - idx[k]) * (c - bp[k]) / (bp[k+1] - bp[k]) + idx[k];
            end
            return 0;
        endfunction

        function logic [W-1:0] clamp_index(input int v);
            return (v > INDEX_MAX) ? W'(INDEX_MAX) : W'(v);
        endfunction

        // At 500 and above PM2.5 passes straight through
        function logic [W-1:0] pm25_subindex(input int c);
            if (c >= 500)
                return clamp_index(c);
            return clamp_index(interpolate(1'b1, c));
        endfunction

        // From 600 up PM10 continues with slope (50/6)/10, 50/6 taken as integer 8
        function logic [W-1:0] pm10_subindex(input int c);
            if (c >= 600)
                return clamp_index((50 / 6) * (c - 600) / 10 + 500);
            return clamp_index(interpolate(1'b0, c));
        endfunction

        function void note_sample(input logic [W-1:0] c25, input logic [W-1:0] c10);
            index_set_t s;
            int         mask;
            mask   = (1 << aqs_pkg::CONC_WIDTH) - 1;
            s.pm25 = pm25_subindex(int'(c25) & mask);
            s.pm10 = pm10_subindex(int'(c10) & mask);
            s.top  = (s.pm25 > s.pm10) ? s.pm25 : s.pm10;
            pending.push_back(s);
        endfunction

        function void check_indices(input logic [W-1:0] got25, input logic [W-1:0] got10,
                                    input logic [W-1:0] gottop);
            index_set_t s;
            if (pending.size() == 0)
            begin
                errors++;
                if (reports < REPORT_LIMIT)
                begin
                    reports++;
                    $display("%0t: result with nothing outstanding: %0d %0d %0d",
                             $realtime, got25, got10, gottop);
                end
                return;
            end
            s = pending.pop_front();
            if (got25 !== s.pm25 || got10 !== s.pm10 || gottop !== s.top)
            begin
                errors++;
                if (reports < REPORT_LIMIT)
                begin
                    reports++;
                    $display({"%0t: mismatch pm25 exp %0d got %0d, ",
                              "pm10 exp %0d got %0d, max exp %0d got %0d"},
                             $realtime, s.pm25, got25, s.pm10, got10, s.top, gottop);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         in_valid  = 1'b0;
    logic         in_stall;
    logic [W-1:0] pm25_conc = '0;
    logic [W-1:0] pm10_conc = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] pm25_index;
    logic [W-1:0] pm10_index;
    logic [W-1:0] max_index;

    int             idle_pct = IDLE_PCT;
    int             quiet_cycles = 0;
    subindex_ledger ledger = new();

    always #2 clk = ~clk;

    air_quality_subindex dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pm25_conc  (pm25_conc),
        .pm10_conc  (pm10_conc),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pm25_index (pm25_index),
        .pm10_index (pm10_index),
        .max_index  (max_index)
    );

    // ------------------------------------------------------------------------
    // Sender: idle at random, then hold the pair until the block takes it.
    // Valid is only ever assigned once per edge: either lowered for a gap or
    // (re)asserted with the next pair.
    // ------------------------------------------------------------------------
    task automatic send_pair(input logic [W-1:0] c25, input logic [W-1:0] c10);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pm25_conc <= c25;
        pm10_conc <= c10;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Transfer taken at this edge: record what it must produce
        ledger.note_sample(c25, c10);
    endtask

    // Half full range, a good share inside the tables, the rest hugging
    // the breakpoints where off-by-one slips show up
    function automatic logic [W-1:0] pick_conc(input bit is_pm25);
        int bp25 [8];
        int bp10 [8];
        int roll;
        int v;
        bp25 = '{0, 35, 75, 115, 150, 250, 350, 500};
        bp10 = '{0, 50, 150, 250, 350, 420, 500, 600};
        roll = $urandom_range(99);
        if (roll < 50)
            return W'($urandom_range(CONC_MAX));
        if (roll < 85)
            return W'($urandom_range(is_pm25 ? 520 : 620));
        v = is_pm25 ? bp25[$urandom_range(7)] : bp10[$urandom_range(7)];
        v = v + int'($urandom_range(2)) - 1;
        if (v < 0)
            v = 0;
        return W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: check every result transfer, then stall at random for the
    // next cycle
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_indices(pm25_index, pm10_index, max_index);
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: count edges with no transfer on either side
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Breakpoints, just below them, the top-segment thresholds either
        // side, both extremes and a few mixed pairs where PM10 wins the max
        int directed25 [24];
        int directed10 [24];
        directed25 = '{0, 35, 75, 115, 150, 250, 350, 500, 34, 499, 501, 4095,
                       4095, 0, 1, 74, 114, 149, 249, 349, 2048, 1365, 600, 36};
        directed10 = '{0, 50, 150, 250, 350, 420, 500, 600, 49, 599, 601, 4095,
                       0, 4095, 1, 149, 249, 349, 419, 499, 1024, 2730, 500, 609};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 24; i++)
            send_pair(W'(directed25[i]), W'(directed10[i]));

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            // Run a stretch flat out on both sides
            idle_pct = (i >= QUIET_FIRST && i < QUIET_LAST) ? 0 : IDLE_PCT;
            send_pair(pick_conc(1'b1), pick_conc(1'b0));
        end
        idle_pct = IDLE_PCT;
        in_valid <= 1'b0;

        // Drain; the watchdog bounds this wait
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.errors == 0 && ledger.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/aqs_pkg.sv
rtl/aqs_front.sv
rtl/aqs_queue.sv
rtl/aqs_back.sv
rtl/air_quality_subindex.sv
verif/air_quality_subindex_test.sv
